// File: rtl/npc_pkg.sv
// shared types and constants for the nearest palette colour search
`timescale 1ns / 1ps

package npc_pkg;

  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int SQ_W    = 2 * COLOR_W;
  localparam int DIST_W  = SQ_W + 2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic load_color;
    logic write_entry;
    logic walk_step;
    logic take_result;
  } npc_cmd_t;

  typedef struct packed {
    logic last_addr;
    logic pipe_busy;
  } npc_status_t;

endpackage

// File: rtl/npc_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module npc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/npc_ctrl.sv
// controller state machine for the palette search
`timescale 1ns / 1ps

module npc_ctrl
  import npc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  output logic        out_valid,
  input  logic        out_stall,
  output npc_cmd_t    cmd,
  input  npc_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next        = state;
    cmd.load_color    = 1'b0;
    cmd.write_entry   = 1'b0;
    cmd.walk_step     = 1'b0;
    cmd.take_result   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_QUERY) begin
            cmd.load_color = 1'b1;
            state_next     = ST_WALK;
          end else begin
            cmd.write_entry = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy && out_free) begin
          cmd.take_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/npc_dp.sv
// datapath: palette store, distance pipeline and best-match tracking
`timescale 1ns / 1ps

module npc_dp
  import npc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  npc_cmd_t           cmd,
  output npc_status_t        status,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  output logic [INDEX_W-1:0] nearest_index
);

  localparam int IdxW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int EntryW = 3 * COLOR_W;

  // palette store and per-entry written flags
  logic [PALETTE_ENTRIES-1:0] entry_vld;
  logic                       wr_en;
  logic [IdxW-1:0]            wr_addr;
  logic [EntryW-1:0]          rd_data;

  // walk and query colour
  logic [IdxW-1:0]    cnt;
  logic [COLOR_W-1:0] q_red;
  logic [COLOR_W-1:0] q_green;
  logic [COLOR_W-1:0] q_blue;

  // stage 1: read data
  logic            s1_valid;
  logic [IdxW-1:0] s1_idx;
  logic            s1_vld;

  // stage 2: squared differences
  logic               s2_valid;
  logic [IdxW-1:0]    s2_idx;
  logic [SQ_W-1:0]    s2_sq_r;
  logic [SQ_W-1:0]    s2_sq_g;
  logic [SQ_W-1:0]    s2_sq_b;

  logic [EntryW-1:0]  s1_entry;
  logic [COLOR_W-1:0] d_r;
  logic [COLOR_W-1:0] d_g;
  logic [COLOR_W-1:0] d_b;
  logic [DIST_W-1:0]  cand_dist;

  logic [IdxW-1:0]    best_idx;
  logic [DIST_W-1:0]  best_dist;

  assign wr_en   = cmd.write_entry &&
                   ({1'b0, entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
  assign wr_addr = entry_index[IdxW-1:0];

  npc_ram #(
    .WIDTH (EntryW),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({red, green, blue}),
    .rd_en   (cmd.walk_step),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  assign status.last_addr = (cnt == IdxW'(PALETTE_ENTRIES - 1));
  assign status.pipe_busy = s1_valid || s2_valid;

  // never-written entries read as black
  assign s1_entry = s1_vld ? rd_data : '0;

  always_comb begin
    logic [COLOR_W-1:0] e_r;
    logic [COLOR_W-1:0] e_g;
    logic [COLOR_W-1:0] e_b;
    e_r = s1_entry[3*COLOR_W-1:2*COLOR_W];
    e_g = s1_entry[2*COLOR_W-1:COLOR_W];
    e_b = s1_entry[COLOR_W-1:0];
    d_r = (q_red   > e_r) ? (q_red   - e_r) : (e_r - q_red);
    d_g = (q_green > e_g) ? (q_green - e_g) : (e_g - q_green);
    d_b = (q_blue  > e_b) ? (q_blue  - e_b) : (e_b - q_blue);
  end

  assign cand_dist = DIST_W'(s2_sq_r) + DIST_W'(s2_sq_g) + DIST_W'(s2_sq_b);

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_vld[wr_addr] <= 1'b1;
      end
      s1_valid <= cmd.walk_step;
      s2_valid <= s1_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_color) begin
      q_red   <= red;
      q_green <= green;
      q_blue  <= blue;
      cnt     <= '0;
    end else if (cmd.walk_step) begin
      cnt <= cnt + IdxW'(1);
    end
    if (cmd.walk_step) begin
      s1_idx <= cnt;
      s1_vld <= entry_vld[cnt];
    end
    if (s1_valid) begin
      s2_idx  <= s1_idx;
      s2_sq_r <= SQ_W'(d_r) * SQ_W'(d_r);
      s2_sq_g <= SQ_W'(d_g) * SQ_W'(d_g);
      s2_sq_b <= SQ_W'(d_b) * SQ_W'(d_b);
    end
    // first entry always taken, then strict less-than keeps the lowest index
    if (s2_valid && ((s2_idx == '0) || (cand_dist < best_dist))) begin
      best_idx  <= s2_idx;
      best_dist <= cand_dist;
    end
    if (cmd.take_result) begin
      nearest_index <= INDEX_W'(best_idx);
    end
  end

endmodule

// File: rtl/nearest_palette_color.sv
// top level of the nearest palette colour search
`timescale 1ns / 1ps

// Nearest palette colour search. The block keeps a palette of
// PALETTE_ENTRIES colours (8-bit red, green, blue), all black after reset.
// Each input beat is either a load (req_type 0), which writes one palette
// entry and gives no result, or a query (req_type 1), which gives one output
// beat carrying the lowest palette index whose squared RGB distance to the
// queried colour is smallest. A load with entry_index at or above
// PALETTE_ENTRIES is dropped. A load never stalls the input, so the next
// beat can follow at once. A query walks the palette one entry per cycle
// through the single read port of the palette ram, so after the query beat
// is taken in_stall stays high through the walk, then the square and
// compare stages and the hand-off to the output register, and the next
// beat can be taken once that hand-off is done. The result sits in an
// output register, so a further load can be taken while an earlier result
// is still stalled; a second query waits only at its hand-off for the
// register to free up.
module nearest_palette_color
  import npc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [INDEX_W-1:0] nearest_index
);

  npc_cmd_t    cmd;
  npc_status_t status;

  // sequencing of loads, the palette walk and the result hand-off
  npc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // palette ram, distance pipeline and running minimum
  npc_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .entry_index   (entry_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .nearest_index (nearest_index)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the nearest palette colour search
`timescale 1ns / 1ps

// The palette is mirrored in the bench. Every accepted load updates the
// mirror. Every accepted query pushes the expected nearest index, which
// comes either from the predictor or, for a few directed rows, from a value
// typed into the table. Result beats are checked in order against that
// queue. The stimulus is a short directed table followed by random traffic
// in three idling phases, with the sender pausing until the block drains.
module tb_top;
  import npc_pkg::*;

  localparam int PALETTE_ENTRIES = 256;
  localparam int RANDOM_BEATS    = 1530;
  // a query holds the block for the walk, the pipeline stages and the result hand-off
  localparam int QUERY_CYCLES    = PALETTE_ENTRIES + 8;
  localparam int MAX_REPORTS     = 20;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  // one input beat, plus an optional hand-typed answer for queries
  typedef struct packed {
    logic               req;
    logic [INDEX_W-1:0] idx;
    rgb_t               colour;
    logic               pinned;
    logic [INDEX_W-1:0] pin;
  } palette_req_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               req_type    = REQ_LOAD;
  logic [INDEX_W-1:0] entry_index = '0;
  logic [COLOR_W-1:0] red         = '0;
  logic [COLOR_W-1:0] green       = '0;
  logic [COLOR_W-1:0] blue        = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [INDEX_W-1:0] nearest_index;

  // mirror of the palette and the indices still owed by the block
  rgb_t               palette_model [PALETTE_ENTRIES];
  logic [INDEX_W-1:0] pending_indices [$];
  palette_req_t       directed_rows [$];

  int send_idle_pct = 9;
  int recv_idle_pct = 78;
  int error_count   = 0;

  nearest_palette_color #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .nearest_index(nearest_index)
  );

  always #5 clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_REPORTS) begin
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // lowest index at the smallest squared rgb distance; strict less-than
  // keeps the earlier entry on a tie, so stopping early on a hit is moot
  function automatic logic [INDEX_W-1:0] nearest_entry(input rgb_t c);
    int dr;
    int dg;
    int db;
    int sum_sq;
    int best_dist;
    logic [INDEX_W-1:0] best;
    best      = '0;
    best_dist = 0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      dr     = int'(c.r) - int'(palette_model[i].r);
      dg     = int'(c.g) - int'(palette_model[i].g);
      db     = int'(c.b) - int'(palette_model[i].b);
      sum_sq = dr * dr + dg * dg + db * db;
      if (i == 0 || sum_sq < best_dist) begin
        best      = INDEX_W'(i);
        best_dist = sum_sq;
      end
    end
    return best;
  endfunction

  // small random offset on one channel, clamped to the colour range
  function automatic logic [COLOR_W-1:0] nudge(input logic [COLOR_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COLOR_W'(v);
  endfunction

  function automatic palette_req_t dir_row(input logic req, input int idx, input int r,
                                           input int g, input int b, input int pin);
    palette_req_t row;
    row.req      = req;
    row.idx      = INDEX_W'(idx);
    row.colour.r = COLOR_W'(r);
    row.colour.g = COLOR_W'(g);
    row.colour.b = COLOR_W'(b);
    row.pinned   = (pin >= 0);
    row.pin      = INDEX_W'(pin < 0 ? 0 : pin);
    return row;
  endfunction

  // drive one beat and hold it until the block takes it, then note what
  // the block now owes us
  task automatic send_beat(input palette_req_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= beat.req;
    entry_index <= beat.idx;
    red         <= beat.colour.r;
    green       <= beat.colour.g;
    blue        <= beat.colour.b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (beat.req == REQ_LOAD) begin
      // loads past the palette size are dropped by the block
      if (int'(beat.idx) < PALETTE_ENTRIES) palette_model[beat.idx] = beat.colour;
    end else begin
      pending_indices.push_back(beat.pinned ? beat.pin : nearest_entry(beat.colour));
    end
  endtask

  // sender stays quiet until every owed result is in, then a query's worth
  // of cycles so that any stray beat would still show up
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_indices.size() != 0) @(posedge clk);
    repeat (QUERY_CYCLES) @(posedge clk);
  endtask

  // result checker: every accepted output beat must match the oldest owed index
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_indices.size() == 0) begin
        report_mismatch("unexpected result beat, nearest_index", int'(nearest_index), -1);
      end else begin
        if (nearest_index !== pending_indices[0]) begin
          report_mismatch("nearest_index", int'(nearest_index), int'(pending_indices[0]));
        end
        void'(pending_indices.pop_front());
      end
    end
  end

  initial begin
    palette_req_t beat;
    int pick;
    int src;

    for (int i = 0; i < PALETTE_ENTRIES; i++) palette_model[i] = '0;

    // directed table; -1 in the last column means ask the predictor
    // empty palette: everything ties at black, so entry 0 wins
    directed_rows.push_back(dir_row(REQ_QUERY, 0, 0, 0, 0, 0));
    directed_rows.push_back(dir_row(REQ_QUERY, 0, 255, 255, 255, 0));
    // top entry set to white
    directed_rows.push_back(dir_row(REQ_LOAD, 255, 255, 255, 255, -1));
    directed_rows.push_back(dir_row(REQ_QUERY, 0, 255, 255, 255, 255));
    directed_rows.push_back(dir_row(REQ_QUERY, 0, 200, 200, 200, 255));
    // primaries at the bottom of the palette
    directed_rows.push_back(dir_row(REQ_LOAD, 0, 255, 0, 0, -1));
    directed_rows.push_back(dir_row(REQ_QUERY, 0, 0, 0, 0, 1));
    directed_rows.push_back(dir_row(REQ_LOAD, 1, 0, 255, 0, -1));
    directed_rows.push_back(dir_row(REQ_LOAD, 2, 0, 0, 255, -1));
    directed_rows.push_back(dir_row(REQ_QUERY, 0, 255, 0, 0, 0));
    directed_rows.push_back(dir_row(REQ_QUERY, 255, 0, 0, 0, 3));
    // duplicate entries: exact hit on both, the lower index must win
    directed_rows.push_back(dir_row(REQ_LOAD, 4, 10, 20, 30, -1));
    directed_rows.push_back(dir_row(REQ_LOAD, 5, 10, 20, 30, -1));
    directed_rows.push_back(dir_row(REQ_QUERY, 0, 10, 20, 30, 4));
    // mid grey and alternating bit patterns
    directed_rows.push_back(dir_row(REQ_LOAD, 128, 128, 128, 128, -1));
    directed_rows.push_back(dir_row(REQ_QUERY, 170, 130, 126, 128, -1));
    directed_rows.push_back(dir_row(REQ_LOAD, 170, 85, 170, 85, -1));
    directed_rows.push_back(dir_row(REQ_LOAD, 85, 170, 85, 170, -1));
    directed_rows.push_back(dir_row(REQ_QUERY, 85, 255, 0, 255, -1));
    directed_rows.push_back(dir_row(REQ_LOAD, 255, 1, 2, 3, -1));
    directed_rows.push_back(dir_row(REQ_QUERY, 0, 255, 255, 255, -1));
    directed_rows.push_back(dir_row(REQ_QUERY, 0, 2, 2, 2, -1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_beat(directed_rows[i]);
    drain_results();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // swap the idling of the two sides, then run flat out
      if (n == RANDOM_BEATS / 3) begin
        drain_results();
        send_idle_pct = 78;
        recv_idle_pct = 9;
      end else if (n == 2 * RANDOM_BEATS / 3) begin
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      beat        = '0;
      beat.idx    = INDEX_W'($urandom_range(255));
      beat.colour = 24'($urandom);
      pick        = $urandom_range(99);
      src         = $urandom_range(PALETTE_ENTRIES - 1);
      if (pick < 40) begin
        beat.req = REQ_LOAD;
      end else if (pick < 50) begin
        // copy an existing entry elsewhere to build ties
        beat.req    = REQ_LOAD;
        beat.colour = palette_model[src];
      end else if (pick < 65) begin
        beat.req = REQ_QUERY;
      end else if (pick < 85) begin
        // near or on an entry already in the palette
        beat.req      = REQ_QUERY;
        beat.colour.r = nudge(palette_model[src].r);
        beat.colour.g = nudge(palette_model[src].g);
        beat.colour.b = nudge(palette_model[src].b);
      end else begin
        // corners of the colour cube
        beat.req      = REQ_QUERY;
        beat.colour.r = {COLOR_W{1'($urandom_range(1))}};
        beat.colour.g = {COLOR_W{1'($urandom_range(1))}};
        beat.colour.b = {COLOR_W{1'($urandom_range(1))}};
      end
      send_beat(beat);
    end

    drain_results();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
